// File: rtl/aow_pkg.sv
// Shared types and constants for the analytics output writer.
// Used by every module in rtl/; depends on nothing.
package aow_pkg;

    localparam int AOW_QUEUE_DEPTH = 2;
    localparam int AOW_MAX_BYTES   = 5;
    localparam int CFG_INDEX_W     = 3;

    // output formats
    localparam logic [1:0] FMT_NOMINAL = 2'd0;
    localparam logic [1:0] FMT_BYTE    = 2'd1;
    localparam logic [1:0] FMT_HALF    = 2'd2;
    localparam logic [1:0] FMT_WORD    = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_SHORT    = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_FORMAT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BIG_ENDIAN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_WIDTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_START_INDEX   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_CAPACITY = 3'd4;

    typedef struct packed {
        logic [31:0] element_value;
        logic        last_element;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        logic [1:0]  status;
        logic [31:0] elements_written;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  out_format;
        logic        big_endian;
        logic [5:0]  element_width;
        logic [31:0] start_index;
        logic [31:0] dest_capacity;
    } cfg_t;

    // one request's worth of bytes, handed from front to back
    typedef struct packed {
        logic [AOW_MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                    nbytes;
        logic                          fin_last;
        logic [1:0]                    fin_status;
        logic [31:0]                   fin_count;
    } desc_t;

endpackage

// File: rtl/aow_front.sv
// Front end: accepts requests, tracks job state and builds byte descriptors.
// Depends on aow_pkg.
module aow_front
    import aow_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     push_valid,
    input  logic     push_ready,
    output desc_t    push_desc
);

    logic        in_job_reg, in_job_next;
    logic        err_reg, err_next;
    logic [7:0]  pend_bits_reg, pend_bits_next;
    logic [2:0]  pend_cnt_reg, pend_cnt_next;
    logic [31:0] scan_reg, scan_next;
    logic [31:0] emitted_reg, emitted_next;
    logic [31:0] bytes_used_reg, bytes_used_next;
    logic [31:0] items_reg, items_next;

    // state as seen by this request (a new job starts from start_index)
    logic        err_cur;
    logic [7:0]  pend_bits;
    logic [2:0]  pend_cnt;
    logic [31:0] scan_cur, emitted_cur, bytes_used_cur;

    logic        accept, last, be;
    logic [5:0]  w, wm, total;
    logic [32:0] mask33;
    logic [31:0] val_m;
    logic [2:0]  nb, rem;
    logic [39:0] acc_le, acc_be, la;
    logic [7:0]  le_tail, be_tail, pend_next, flush_byte;
    logic        flush;
    logic [AOW_MAX_BYTES-1:0][7:0] nom_bytes;
    logic [2:0]  nom_n;

    // word formats
    logic [2:0]  size;
    logic [5:0]  fbits;
    logic        idx_over, over_w, have, short_dest;
    logic [1:0]  wstatus;
    logic [31:0] word;
    logic [32:0] need;
    logic [AOW_MAX_BYTES-1:0][7:0] wbytes;

    desc_t       desc;

    assign accept   = in_valid && push_ready;
    assign in_ready = push_ready;
    assign last     = in_data.last_element;
    assign be       = cfg.big_endian;
    assign w        = cfg.element_width;

    assign err_cur        = in_job_reg ? err_reg : 1'b0;
    assign pend_bits      = in_job_reg ? pend_bits_reg : 8'd0;
    assign pend_cnt       = in_job_reg ? pend_cnt_reg : 3'd0;
    assign scan_cur       = in_job_reg ? scan_reg : cfg.start_index;
    assign emitted_cur    = in_job_reg ? emitted_reg : cfg.start_index;
    assign bytes_used_cur = in_job_reg ? bytes_used_reg : 32'd0;

    // bit-packed path
    always_comb
    begin
        wm     = (w > 6'd32) ? 6'd32 : w;
        mask33 = (33'd1 << wm) - 33'd1;
        val_m  = in_data.element_value & mask33[31:0];
        total  = {3'b000, pend_cnt} + wm;
        nb     = total[5:3];
        rem    = total[2:0];
        acc_le = {32'd0, pend_bits} | ({8'd0, val_m} << pend_cnt);
        acc_be = ({32'd0, pend_bits} << wm) | {8'd0, val_m};
        // left-align the valid bits so byte k sits at a fixed place
        la      = acc_be << (6'd40 - total);
        le_tail = 8'(acc_le >> {nb, 3'b000});
        be_tail = acc_be[7:0] & ((8'd1 << rem) - 8'd1);
        pend_next = be ? be_tail : le_tail;
        flush   = last && (rem != 3'd0);
        if (!flush)
            flush_byte = 8'd0;
        else if (be)
            flush_byte = be_tail << (4'd8 - {1'b0, rem});
        else
            flush_byte = le_tail;
        for (int k = 0; k < AOW_MAX_BYTES; k++)
        begin
            if (3'(k) < nb)
                nom_bytes[k] = be ? la[39-8*k -: 8] : acc_le[8*k +: 8];
            else if (3'(k) == nb)
                nom_bytes[k] = flush_byte;
            else
                nom_bytes[k] = 8'd0;
        end
        nom_n = nb + {2'b00, flush};
        if (last && nom_n == 3'd0)
            nom_n = 3'd1;      // carrier result
    end

    // word formats
    always_comb
    begin
        unique case (cfg.out_format)
            FMT_BYTE:
            begin
                size = 3'd1; fbits = 6'd8;  idx_over = |scan_cur[31:8];
            end
            FMT_HALF:
            begin
                size = 3'd2; fbits = 6'd16; idx_over = |scan_cur[31:16];
            end
            default:
            begin
                size = 3'd4; fbits = 6'd32; idx_over = 1'b0;
            end
        endcase
        over_w  = w > fbits;
        have    = 1'b0;
        wstatus = STATUS_OK;
        word    = val_m;
        if (over_w)
            wstatus = STATUS_OVERFLOW;
        else if (w == 6'd1)
        begin
            word = scan_cur;
            if (val_m != 32'd0)
            begin
                if (idx_over)
                    wstatus = STATUS_OVERFLOW;
                else
                    have = 1'b1;
            end
        end
        else
            have = 1'b1;
        need       = {1'b0, bytes_used_cur} + {30'd0, size};
        short_dest = have && (need > {1'b0, cfg.dest_capacity});
        if (short_dest)
            wstatus = STATUS_SHORT;

        wbytes = '0;
        unique case (cfg.out_format)
            FMT_BYTE:
                wbytes[0] = word[7:0];
            FMT_HALF:
            begin
                wbytes[0] = be ? word[15:8] : word[7:0];
                wbytes[1] = be ? word[7:0]  : word[15:8];
            end
            default:
            begin
                wbytes[0] = be ? word[31:24] : word[7:0];
                wbytes[1] = be ? word[23:16] : word[15:8];
                wbytes[2] = be ? word[15:8]  : word[23:16];
                wbytes[3] = be ? word[7:0]   : word[31:24];
            end
        endcase
    end

    // descriptor and next state
    always_comb
    begin
        in_job_next     = in_job_reg;
        err_next        = err_cur;
        pend_bits_next  = pend_bits;
        pend_cnt_next   = pend_cnt;
        scan_next       = scan_cur;
        emitted_next    = emitted_cur;
        bytes_used_next = bytes_used_cur;
        items_next      = (in_job_reg ? items_reg : 32'd0) + 32'd1;

        desc            = '0;
        desc.fin_status = STATUS_OK;
        desc.fin_last   = last;

        if (accept)
            in_job_next = !last;

        if (err_cur)
        begin
            desc.nbytes = 3'd0;    // dropped until the end of the job
        end
        else if (cfg.out_format == FMT_NOMINAL)
        begin
            desc.bytes     = nom_bytes;
            desc.nbytes    = nom_n;
            desc.fin_count = last ? items_next : 32'd0;
            pend_bits_next = last ? 8'd0 : pend_next;
            pend_cnt_next  = last ? 3'd0 : rem;
        end
        else
        begin
            if (w == 6'd1)
                scan_next = scan_cur + 32'd1;
            if (wstatus != STATUS_OK)
            begin
                err_next        = 1'b1;
                desc.nbytes     = 3'd1;
                desc.fin_status = wstatus;
                desc.fin_count  = emitted_cur;
            end
            else
            begin
                if (have)
                begin
                    desc.bytes      = wbytes;
                    desc.nbytes     = size;
                    bytes_used_next = need[31:0];
                    emitted_next    = emitted_cur + 32'd1;
                end
                if (last && !have)
                    desc.nbytes = 3'd1;
                desc.fin_count = last ? emitted_next : 32'd0;
            end
        end
    end

    assign push_valid = accept && (desc.nbytes != 3'd0);
    assign push_desc  = desc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_job_reg     <= 1'b0;
            err_reg        <= 1'b0;
            pend_bits_reg  <= 8'd0;
            pend_cnt_reg   <= 3'd0;
            scan_reg       <= 32'd0;
            emitted_reg    <= 32'd0;
            bytes_used_reg <= 32'd0;
            items_reg      <= 32'd0;
        end
        else if (accept)
        begin
            in_job_reg     <= in_job_next;
            err_reg        <= err_next;
            pend_bits_reg  <= pend_bits_next;
            pend_cnt_reg   <= pend_cnt_next;
            scan_reg       <= scan_next;
            emitted_reg    <= emitted_next;
            bytes_used_reg <= bytes_used_next;
            items_reg      <= items_next;
        end
    end

endmodule

// File: rtl/aow_queue.sv
// Small descriptor FIFO between the front end and the byte serializer.
// Depends on aow_pkg.
module aow_queue
    import aow_pkg::*;
#(
    parameter int DEPTH = AOW_QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  desc_t push_desc,
    output logic  pop_valid,
    input  logic  pop,
    output desc_t pop_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            entries[DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_desc   = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: rtl/aow_back.sv
// Back end: walks a descriptor one byte per cycle into the output register unless stalled.
// Depends on aow_pkg.
module aow_back
    import aow_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  desc_t     q_desc,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg;
    out_item_t  out_data_reg, out_data_next;
    logic       emit, final_byte;

    assign emit       = q_valid && (!out_valid_reg || out_ready);
    assign final_byte = idx_reg == (q_desc.nbytes - 3'd1);
    assign q_pop      = emit && final_byte;
    assign idx_next   = final_byte ? 3'd0 : idx_reg + 3'd1;

    // status and count ride only on the final byte of a request
    always_comb
    begin
        out_data_next.out_byte         = q_desc.bytes[idx_reg];
        out_data_next.out_last         = final_byte && q_desc.fin_last;
        out_data_next.status           = final_byte ? q_desc.fin_status : STATUS_OK;
        out_data_next.elements_written = final_byte ? q_desc.fin_count : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                idx_reg       <= idx_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/analytics_output_writer.sv
// Top level of the analytics output writer: config registers and wiring.
// Depends on aow_pkg, aow_front, aow_queue, aow_back.
//
//  channel  handshake              payload
//  -------  ---------------------  ---------------------------------
//  in       in_valid / in_ready    in_data  (in_item_t)
//  out      out_valid / out_ready  out_data (out_item_t), one byte each
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// A request is classified in the cycle it is taken; its bytes (0 to 5)
// leave one per cycle while the output is not stalled (4 for 32-bit words),
// so the output port bounds the sustained request rate.
// A QUEUE_DEPTH descriptor FIFO lets input and output stall independently.
// Reset clears job state and sets configuration to its defaults; no clearing pass is needed.
module analytics_output_writer
    import aow_pkg::*;
#(
    parameter int QUEUE_DEPTH = AOW_QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    cfg_t  cfg_reg;
    logic  push_valid, push_ready, pop_valid, pop;
    desc_t push_desc, pop_desc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.out_format    <= FMT_NOMINAL;
            cfg_reg.big_endian    <= 1'b0;
            cfg_reg.element_width <= 6'd1;
            cfg_reg.start_index   <= 32'd0;
            cfg_reg.dest_capacity <= 32'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_OUT_FORMAT:    cfg_reg.out_format    <= cfg_data[1:0];
                REG_BIG_ENDIAN:    cfg_reg.big_endian    <= cfg_data[0];
                REG_ELEMENT_WIDTH: cfg_reg.element_width <= cfg_data[5:0];
                REG_START_INDEX:   cfg_reg.start_index   <= cfg_data;
                REG_DEST_CAPACITY: cfg_reg.dest_capacity <= cfg_data;
                default: ;
            endcase
        end
    end

    aow_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    aow_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_desc   (pop_desc)
    );

    aow_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_desc    (pop_desc),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
